// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the frame receive block. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define FRC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("frc assertion failed");

// cond must never be seen at a clock edge outside reset
`define FRC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("frc forbidden condition seen");

`else

`define FRC_ASSERT(lbl, clk, rst_n, prop)
`define FRC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the frame receive / CRC check block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frc_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int CRC_W  = 16;
	localparam int POS_W  = 7;
	localparam int IDX_W  = 6;
	localparam int CFG_W  = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	localparam logic [BYTE_W-1:0] RST_START_ONE = 8'hA5;
	localparam logic [BYTE_W-1:0] RST_START_TWO = 8'h5A;
	localparam logic [BYTE_W-1:0] RST_END       = 8'h7E;

	// configuration register indexes
	localparam logic [CFG_W-1:0] CFG_START_ONE = 2'd0;
	localparam logic [CFG_W-1:0] CFG_START_TWO = 2'd1;
	localparam logic [CFG_W-1:0] CFG_END       = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;

	typedef enum logic [3:0] {
		PH_SOF1    = 4'd0,
		PH_SOF2    = 4'd1,
		PH_VER     = 4'd2,
		PH_TYPE    = 4'd3,
		PH_FLAGS   = 4'd4,
		PH_SEQ     = 4'd5,
		PH_LEN_L   = 4'd6,
		PH_LEN_H   = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_CRC_L   = 4'd9,
		PH_CRC_H   = 4'd10,
		PH_EOF     = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		CTL_IDLE = 3'd0,
		CTL_CRC  = 3'd1,
		CTL_ONE  = 3'd2,
		CTL_RD   = 3'd3,
		CTL_WR   = 3'd4
	} ctl_t;

	typedef struct packed {
		logic clear;
		logic start;
	} crc_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} crc_sts_t;

endpackage

// File: hw/rtl/frc_crc_unit.sv
// ----------------------------------------------------------------------------
// frc_crc_unit
// Bit-serial CRC-16 (poly 0x1021, MSB first): one data bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frc_crc_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frc_pkg::crc_ctl_t                 ctl,
	input  logic [frc_pkg::BYTE_W-1:0]        data,
	output frc_pkg::crc_sts_t                 sts,
	output logic [frc_pkg::CRC_W-1:0]         crc
);

	logic [frc_pkg::CRC_W-1:0]  crc_q;
	logic [frc_pkg::BYTE_W-1:0] data_q;
	logic [2:0]                 cnt_q;
	logic                       busy_q;
	logic                       fb;

	assign fb       = crc_q[frc_pkg::CRC_W-1] ^ data_q[frc_pkg::BYTE_W-1];
	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == 3'd7);
	assign crc      = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= frc_pkg::CRC_INIT;
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (ctl.clear) begin
			crc_q <= frc_pkg::CRC_INIT;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (busy_q) begin
			crc_q <= {crc_q[frc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? frc_pkg::CRC_POLY : '0);
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// data shift register, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			data_q <= data;
		end else if (busy_q) begin
			data_q <= {data_q[frc_pkg::BYTE_W-2:0], 1'b0};
		end
	end

endmodule

// File: hw/rtl/frc_payload_ram.sv
// ----------------------------------------------------------------------------
// frc_payload_ram
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frc_payload_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [frc_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [frc_pkg::BYTE_W-1:0] rdata
);

	logic [frc_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [frc_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/frame_receive_crc_check.sv
// ----------------------------------------------------------------------------
// frame_receive_crc_check
// Input: start and CRC bytes are taken without holding the input; a header or
//   payload byte holds it while the bit-serial CRC unit steps through its bits.
// Results: the deciding byte holds the input until one result, or each payload
//   byte read from the store, is loaded into the output register past any stall.
// Reset: arst_n async low; hunt state, CRC 0xFFFF, counters zero, default
//   delimiters. The payload store is not cleared.
// Byte-serial deframer: start bytes, header, little-endian length, payload,
// little-endian CRC-16/CCITT-FALSE and end byte, checked and delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_receive_crc_check #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input byte channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [frc_pkg::BYTE_W-1:0] rx_byte,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [frc_pkg::BYTE_W-1:0] version,
	output logic [frc_pkg::BYTE_W-1:0] frame_type,
	output logic [frc_pkg::BYTE_W-1:0] frame_flags,
	output logic [frc_pkg::BYTE_W-1:0] sequence_res,
	output logic [frc_pkg::LEN_W-1:0]  payload_length,
	output logic                       has_byte,
	output logic [frc_pkg::IDX_W-1:0]  payload_index,
	output logic [frc_pkg::BYTE_W-1:0] payload_byte,
	output logic                       last_of_run,
	output logic [frc_pkg::LEN_W-1:0]  error_total,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [frc_pkg::CFG_W-1:0]  cfg_index,
	input  logic [frc_pkg::BYTE_W-1:0] cfg_data
);

	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [frc_pkg::LEN_W-1:0] LEN_MAX = frc_pkg::LEN_W'(PAYLOAD_DEPTH);
	localparam logic [frc_pkg::POS_W-1:0] POS_MAX = frc_pkg::POS_W'(PAYLOAD_DEPTH);

	// configuration registers
	logic [frc_pkg::BYTE_W-1:0] start_one_q, start_two_q, end_byte_q;

	// parser state
	frc_pkg::phase_t            phase_q, phase_d;
	logic [frc_pkg::BYTE_W-1:0] ver_q, ver_d, type_q, type_d;
	logic [frc_pkg::BYTE_W-1:0] flags_q, flags_d, seq_q, seq_d;
	logic [frc_pkg::LEN_W-1:0]  len_q, len_d;
	logic [frc_pkg::CRC_W-1:0]  crc_rx_q, crc_rx_d;
	logic [frc_pkg::POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [frc_pkg::LEN_W-1:0]  err_q, err_d;
	logic [1:0]                 res_status_q, res_status_d;
	logic [frc_pkg::LEN_W-1:0]  len_new;

	// sequencer
	frc_pkg::ctl_t              ctl_q, ctl_d;
	logic [frc_pkg::POS_W-1:0]  emit_idx_q, emit_inc;
	logic                       emit_last;

	logic                       in_acc;
	logic                       need_crc, need_one, need_emit;
	logic                       out_free, load_one, load_pay, ram_re;
	logic                       ram_we;

	frc_pkg::crc_ctl_t          crc_ctl;
	frc_pkg::crc_sts_t          crc_sts;
	logic [frc_pkg::CRC_W-1:0]  crc_val;
	logic [frc_pkg::BYTE_W-1:0] ram_rdata;

	// output register
	logic                       out_valid_q;
	logic [1:0]                 out_status_q;
	logic                       out_has_q, out_last_q;
	logic [frc_pkg::IDX_W-1:0]  out_idx_q;
	logic [frc_pkg::BYTE_W-1:0] out_byte_q;
	logic [frc_pkg::BYTE_W-1:0] out_ver_q, out_type_q, out_flags_q, out_seq_q;
	logic [frc_pkg::LEN_W-1:0]  out_len_q, out_err_q;

	// an input byte is taken only while the sequencer is idle
	assign in_stall  = (ctl_q != frc_pkg::CTL_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign len_new   = {rx_byte, len_q[frc_pkg::BYTE_W-1:0]};
	assign pos_inc   = pos_q + frc_pkg::POS_W'(1);
	assign emit_inc  = emit_idx_q + frc_pkg::POS_W'(1);
	assign emit_last = ({{(frc_pkg::LEN_W-frc_pkg::POS_W){1'b0}}, emit_inc} == len_q);

	// ------------------------------------------------------------------
	// Parser: next phase and header/CRC/error fields on an accepted byte
	// ------------------------------------------------------------------
	always_comb begin
		phase_d      = phase_q;
		ver_d        = ver_q;
		type_d       = type_q;
		flags_d      = flags_q;
		seq_d        = seq_q;
		len_d        = len_q;
		crc_rx_d     = crc_rx_q;
		pos_d        = pos_q;
		err_d        = err_q;
		res_status_d = res_status_q;
		need_crc     = 1'b0;
		need_one     = 1'b0;
		need_emit    = 1'b0;
		ram_we       = 1'b0;
		crc_ctl      = '0;
		if (in_acc) begin
			case (phase_q)
				frc_pkg::PH_SOF2: begin
					if (rx_byte == start_two_q) begin
						phase_d       = frc_pkg::PH_VER;
						crc_ctl.clear = 1'b1;
					end else begin
						phase_d = frc_pkg::PH_SOF1;
					end
				end
				frc_pkg::PH_VER: begin
					ver_d    = rx_byte;
					need_crc = 1'b1;
					phase_d  = frc_pkg::PH_TYPE;
				end
				frc_pkg::PH_TYPE: begin
					type_d   = rx_byte;
					need_crc = 1'b1;
					phase_d  = frc_pkg::PH_FLAGS;
				end
				frc_pkg::PH_FLAGS: begin
					flags_d  = rx_byte;
					need_crc = 1'b1;
					phase_d  = frc_pkg::PH_SEQ;
				end
				frc_pkg::PH_SEQ: begin
					seq_d    = rx_byte;
					need_crc = 1'b1;
					phase_d  = frc_pkg::PH_LEN_L;
				end
				frc_pkg::PH_LEN_L: begin
					len_d    = {{(frc_pkg::LEN_W-frc_pkg::BYTE_W){1'b0}}, rx_byte};
					need_crc = 1'b1;
					phase_d  = frc_pkg::PH_LEN_H;
				end
				frc_pkg::PH_LEN_H: begin
					len_d = len_new;
					pos_d = '0;
					if (len_new > LEN_MAX) begin
						// CRC is dead here: it restarts on the second start byte of the next frame
						err_d        = err_q + frc_pkg::LEN_W'(1);
						res_status_d = frc_pkg::ST_BAD_LEN;
						need_one     = 1'b1;
						phase_d      = frc_pkg::PH_SOF1;
					end else begin
						need_crc = 1'b1;
						phase_d  = (len_new == '0) ? frc_pkg::PH_CRC_L : frc_pkg::PH_PAYLOAD;
					end
				end
				frc_pkg::PH_PAYLOAD: begin
					ram_we   = (pos_q < POS_MAX);
					pos_d    = pos_inc;
					need_crc = 1'b1;
					if ({{(frc_pkg::LEN_W-frc_pkg::POS_W){1'b0}}, pos_inc} >= len_q) begin
						phase_d = frc_pkg::PH_CRC_L;
					end
				end
				frc_pkg::PH_CRC_L: begin
					crc_rx_d = {{(frc_pkg::CRC_W-frc_pkg::BYTE_W){1'b0}}, rx_byte};
					phase_d  = frc_pkg::PH_CRC_H;
				end
				frc_pkg::PH_CRC_H: begin
					crc_rx_d = {rx_byte, crc_rx_q[frc_pkg::BYTE_W-1:0]};
					phase_d  = frc_pkg::PH_EOF;
				end
				frc_pkg::PH_EOF: begin
					phase_d = frc_pkg::PH_SOF1;
					if ((rx_byte == end_byte_q) && (crc_rx_q == crc_val)) begin
						if (len_q == '0) begin
							res_status_d = frc_pkg::ST_OK;
							need_one     = 1'b1;
						end else begin
							need_emit = 1'b1;
						end
					end else begin
						err_d        = err_q + frc_pkg::LEN_W'(1);
						res_status_d = (rx_byte == end_byte_q) ? frc_pkg::ST_BAD_CRC
						                                       : frc_pkg::ST_BAD_LEN;
						need_one     = 1'b1;
					end
				end
				default: begin
					// hunt, and any unused phase code
					phase_d = (rx_byte == start_one_q) ? frc_pkg::PH_SOF2 : frc_pkg::PH_SOF1;
				end
			endcase
		end
		crc_ctl.start = need_crc;
	end

	// ------------------------------------------------------------------
	// Sequencer next state
	// ------------------------------------------------------------------
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			frc_pkg::CTL_IDLE: begin
				if (need_crc) begin
					ctl_d = frc_pkg::CTL_CRC;
				end else if (need_one) begin
					ctl_d = frc_pkg::CTL_ONE;
				end else if (need_emit) begin
					ctl_d = frc_pkg::CTL_RD;
				end
			end
			frc_pkg::CTL_CRC: begin
				if (crc_sts.done) begin
					ctl_d = frc_pkg::CTL_IDLE;
				end
			end
			frc_pkg::CTL_ONE: begin
				if (out_free) begin
					ctl_d = frc_pkg::CTL_IDLE;
				end
			end
			frc_pkg::CTL_RD: begin
				ctl_d = frc_pkg::CTL_WR;
			end
			frc_pkg::CTL_WR: begin
				if (out_free) begin
					ctl_d = emit_last ? frc_pkg::CTL_IDLE : frc_pkg::CTL_RD;
				end
			end
			default: begin
				ctl_d = frc_pkg::CTL_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ram_re   = (ctl_q == frc_pkg::CTL_RD);
		load_one = (ctl_q == frc_pkg::CTL_ONE) && out_free;
		load_pay = (ctl_q == frc_pkg::CTL_WR) && out_free;
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_one_q  <= frc_pkg::RST_START_ONE;
			start_two_q  <= frc_pkg::RST_START_TWO;
			end_byte_q   <= frc_pkg::RST_END;
			phase_q      <= frc_pkg::PH_SOF1;
			ver_q        <= '0;
			type_q       <= '0;
			flags_q      <= '0;
			seq_q        <= '0;
			len_q        <= '0;
			crc_rx_q     <= '0;
			pos_q        <= '0;
			err_q        <= '0;
			res_status_q <= frc_pkg::ST_OK;
			ctl_q        <= frc_pkg::CTL_IDLE;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					frc_pkg::CFG_START_ONE: start_one_q <= cfg_data;
					frc_pkg::CFG_START_TWO: start_two_q <= cfg_data;
					frc_pkg::CFG_END:       end_byte_q  <= cfg_data;
					default: ;
				endcase
			end
			phase_q      <= phase_d;
			ver_q        <= ver_d;
			type_q       <= type_d;
			flags_q      <= flags_d;
			seq_q        <= seq_d;
			len_q        <= len_d;
			crc_rx_q     <= crc_rx_d;
			pos_q        <= pos_d;
			err_q        <= err_d;
			res_status_q <= res_status_d;
			ctl_q        <= ctl_d;
			if (need_emit) begin
				emit_idx_q <= '0;
			end else if (load_pay) begin
				emit_idx_q <= emit_inc;
			end
			if (load_one || load_pay) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload register; header fields are stable while a run drains
	always_ff @(posedge clk) begin
		if (load_one || load_pay) begin
			out_ver_q   <= ver_q;
			out_type_q  <= type_q;
			out_flags_q <= flags_q;
			out_seq_q   <= seq_q;
			out_len_q   <= len_q;
			out_err_q   <= err_q;
		end
		if (load_one) begin
			out_status_q <= res_status_q;
			out_has_q    <= 1'b0;
			out_idx_q    <= '0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (load_pay) begin
			out_status_q <= frc_pkg::ST_OK;
			out_has_q    <= 1'b1;
			out_idx_q    <= emit_idx_q[frc_pkg::IDX_W-1:0];
			out_byte_q   <= ram_rdata;
			out_last_q   <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign version        = out_ver_q;
	assign frame_type     = out_type_q;
	assign frame_flags    = out_flags_q;
	assign sequence_res   = out_seq_q;
	assign payload_length = out_len_q;
	assign has_byte       = out_has_q;
	assign payload_index  = out_idx_q;
	assign payload_byte   = out_byte_q;
	assign last_of_run    = out_last_q;
	assign error_total    = out_err_q;

	// ------------------------------------------------------------------
	// Shared CRC unit and payload store
	// ------------------------------------------------------------------
	frc_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rx_byte),
		.sts    (crc_sts),
		.crc    (crc_val)
	);

	frc_payload_ram #(
		.DEPTH  (PAYLOAD_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q[ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (emit_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`FRC_ASSERT_NEVER(a_crc_busy_ctl, clk, arst_n, crc_sts.busy && (ctl_q != frc_pkg::CTL_CRC))
	`FRC_ASSERT(a_pay_ok, clk, arst_n, (out_valid_q && out_has_q) |-> (out_status_q == frc_pkg::ST_OK))
	`FRC_ASSERT(a_emit_in_len, clk, arst_n, (ctl_q == frc_pkg::CTL_WR) |-> ({{(frc_pkg::LEN_W-frc_pkg::POS_W){1'b0}}, emit_idx_q} < len_q))
	`FRC_ASSERT(a_err_step, clk, arst_n, (err_q != $past(err_q)) |-> (err_q == frc_pkg::LEN_W'($past(err_q) + frc_pkg::LEN_W'(1))))

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_receive_crc_check. Frames are built byte by
// byte, with good and corrupted CRCs, wrong end and start bytes, oversize
// lengths and line noise. Each accepted byte goes through a predictor in a
// small scoreboard class. Every result transaction is checked in order
// against the predicted queue. Both channels idle at random, and the result
// side is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import frc_pkg::*;

	localparam int DEPTH         = 64;
	localparam int IDLE_PCT      = 36;
	// outlasts a full-payload frame, so its results back up into the input
	localparam int HOLD_CYCLES   = 2000;
	localparam int SETTLE_CYCLES = 32;
	localparam int PHASE_BYTES   = 35;
	localparam int MAX_REPORTS   = 10;
	// 10 ms of 20 ns cycles: far above the slowest legal run of this stimulus
	localparam longint LIMIT_NS  = 64'd10_000_000;

	// index two bits wide, only three registers behind it
	localparam logic [CFG_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		FK_GOOD,
		FK_BAD_CRC,
		FK_BAD_END,
		FK_BAD_LEN,
		FK_BAD_SOF,
		FK_NOISE
	} frame_kind_e;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] version;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] frame_flags;
		logic [BYTE_W-1:0] sequence_res;
		logic [LEN_W-1:0]  payload_length;
		logic              has_byte;
		logic [IDX_W-1:0]  payload_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              last_of_run;
		logic [LEN_W-1:0]  error_total;
	} frame_result_t;

	// ------------------------------------------------------------------------
	// Deframer predictor plus the queue of results it has announced.
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		logic [BYTE_W-1:0] sof_one;
		logic [BYTE_W-1:0] sof_two;
		logic [BYTE_W-1:0] eof_byte;
		phase_t            phase;
		logic [CRC_W-1:0]  crc_acc;
		logic [CRC_W-1:0]  crc_rx;
		logic [BYTE_W-1:0] hdr_ver;
		logic [BYTE_W-1:0] hdr_typ;
		logic [BYTE_W-1:0] hdr_flg;
		logic [BYTE_W-1:0] hdr_seq;
		logic [LEN_W-1:0]  hdr_len;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] store [DEPTH];
		logic [LEN_W-1:0]  err_cnt;
		frame_result_t     expected_q [$];
		int                mismatches;

		function new();
			sof_one    = RST_START_ONE;
			sof_two    = RST_START_TWO;
			eof_byte   = RST_END;
			phase      = PH_SOF1;
			crc_acc    = CRC_INIT;
			crc_rx     = '0;
			hdr_ver    = '0;
			hdr_typ    = '0;
			hdr_flg    = '0;
			hdr_seq    = '0;
			hdr_len    = '0;
			pos        = '0;
			err_cnt    = '0;
			mismatches = 0;
		endfunction

		// CRC-16, MSB first, one byte
		static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc,
				logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] c;
			c = crc ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
			return c;
		endfunction

		function void write_reg(logic [CFG_W-1:0] idx, logic [BYTE_W-1:0] val);
			case (idx)
				CFG_START_ONE: sof_one = val;
				CFG_START_TWO: sof_two = val;
				CFG_END:       eof_byte = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_result(logic [1:0] st, logic has, logic [IDX_W-1:0] idx,
				logic [BYTE_W-1:0] pb, logic last);
			frame_result_t r;
			r.status         = st;
			r.version        = hdr_ver;
			r.frame_type     = hdr_typ;
			r.frame_flags    = hdr_flg;
			r.sequence_res   = hdr_seq;
			r.payload_length = hdr_len;
			r.has_byte       = has;
			r.payload_index  = idx;
			r.payload_byte   = pb;
			r.last_of_run    = last;
			r.error_total    = err_cnt;
			expected_q.push_back(r);
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b);
			case (phase)
				PH_SOF2: begin
					if (b == sof_two) begin
						phase   = PH_VER;
						crc_acc = CRC_INIT;
					end else begin
						phase = PH_SOF1;
					end
				end
				PH_VER: begin
					hdr_ver = b;
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_TYPE;
				end
				PH_TYPE: begin
					hdr_typ = b;
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_FLAGS;
				end
				PH_FLAGS: begin
					hdr_flg = b;
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_SEQ;
				end
				PH_SEQ: begin
					hdr_seq = b;
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_LEN_L;
				end
				PH_LEN_L: begin
					hdr_len = {8'h00, b};
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_LEN_H;
				end
				PH_LEN_H: begin
					hdr_len[15:8] = b;
					crc_acc = crc_step(crc_acc, b);
					pos     = '0;
					if (hdr_len > DEPTH) begin
						err_cnt++;
						add_result(ST_BAD_LEN, 1'b0, '0, '0, 1'b1);
						phase = PH_SOF1;
					end else if (hdr_len == 0) begin
						phase = PH_CRC_L;
					end else begin
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (pos < DEPTH)
						store[pos[IDX_W-1:0]] = b;
					pos     = pos + 1'b1;
					crc_acc = crc_step(crc_acc, b);
					if (LEN_W'(pos) >= hdr_len)
						phase = PH_CRC_L;
				end
				PH_CRC_L: begin
					crc_rx = {8'h00, b};
					phase  = PH_CRC_H;
				end
				PH_CRC_H: begin
					crc_rx[15:8] = b;
					phase = PH_EOF;
				end
				PH_EOF: begin
					if (b == eof_byte && crc_rx == crc_acc) begin
						if (hdr_len == 0)
							add_result(ST_OK, 1'b0, '0, '0, 1'b1);
						else
							for (int i = 0; i < hdr_len; i++)
								add_result(ST_OK, 1'b1, IDX_W'(i), store[i],
									i == hdr_len - 1);
					end else begin
						err_cnt++;
						add_result((b == eof_byte) ? ST_BAD_CRC : ST_BAD_LEN,
							1'b0, '0, '0, 1'b1);
					end
					phase = PH_SOF1;
				end
				default: phase = (b == sof_one) ? PH_SOF2 : PH_SOF1;
			endcase
		endfunction

		function string fmt(frame_result_t r);
			return $sformatf(
				{"st=%0d ver=%02h typ=%02h flg=%02h seq=%02h len=%0d ",
				 "has=%0b idx=%0d byte=%02h last=%0b err=%0d"},
				r.status, r.version, r.frame_type, r.frame_flags, r.sequence_res,
				r.payload_length, r.has_byte, r.payload_index, r.payload_byte,
				r.last_of_run, r.error_total);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t exp_r;
			bit            wrong;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb: unexpected result @%0t: %s", $time, fmt(got));
				return;
			end
			exp_r = expected_q.pop_front();
			wrong = (got.status !== exp_r.status)
				|| (got.version !== exp_r.version)
				|| (got.frame_type !== exp_r.frame_type)
				|| (got.frame_flags !== exp_r.frame_flags)
				|| (got.sequence_res !== exp_r.sequence_res)
				|| (got.payload_length !== exp_r.payload_length)
				|| (got.has_byte !== exp_r.has_byte)
				|| (got.payload_index !== exp_r.payload_index)
				|| (got.payload_byte !== exp_r.payload_byte)
				|| (got.last_of_run !== exp_r.last_of_run)
				|| (got.error_total !== exp_r.error_total);
			if (wrong) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb: mismatch @%0t\n  exp %s\n  got %s", $time,
						fmt(exp_r), fmt(got));
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------------
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_W-1:0]  cfg_index = '0;
	logic [BYTE_W-1:0] cfg_data  = '0;

	logic              in_stall;
	logic              out_valid;
	logic [1:0]        status;
	logic [BYTE_W-1:0] version;
	logic [BYTE_W-1:0] frame_type;
	logic [BYTE_W-1:0] frame_flags;
	logic [BYTE_W-1:0] sequence_res;
	logic [LEN_W-1:0]  payload_length;
	logic              has_byte;
	logic [IDX_W-1:0]  payload_index;
	logic [BYTE_W-1:0] payload_byte;
	logic              last_of_run;
	logic [LEN_W-1:0]  error_total;
	logic              cfg_ready;

	frame_scoreboard sb = new();
	frame_result_t   seen;

	bit idle_en     = 1'b1;  // random idling on both channels
	bit hold_req    = 1'b0;  // main thread asks the result side to hold off
	int hold_left   = 0;
	int frame_bytes = 0;     // bytes sent in the current random budget

	frame_receive_crc_check #(
		.PAYLOAD_DEPTH(DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.version       (version),
		.frame_type    (frame_type),
		.frame_flags   (frame_flags),
		.sequence_res  (sequence_res),
		.payload_length(payload_length),
		.has_byte      (has_byte),
		.payload_index (payload_index),
		.payload_byte  (payload_byte),
		.last_of_run   (last_of_run),
		.error_total   (error_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop in case the DUT hangs
	initial begin
		#(LIMIT_NS);
		$display("tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side. Sample right after the edge (pre-edge values), then pick
	// the stall for the next cycle. A hold-off request pins stall high for
	// HOLD_CYCLES; the count lives here so the sender keeps pushing meanwhile.
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				seen = {status, version, frame_type, frame_flags, sequence_res,
					payload_length, has_byte, payload_index, payload_byte,
					last_of_run, error_total};
				sb.check_result(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Byte channel driver. An optional idle gap goes first, so valid is only
	// ever dropped in a step where it is not also raised. The payload holds
	// until the transaction completes (valid high, stall low at an edge).
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_en && $urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_byte(b);
	endtask

	// caller lowers cfg_valid after the last write of a batch
	task automatic cfg_write(input logic [CFG_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, val);
	endtask

	task automatic load_config(input logic [BYTE_W-1:0] one, input logic [BYTE_W-1:0] two,
			input logic [BYTE_W-1:0] eof);
		cfg_write(CFG_START_ONE, one);
		cfg_write(CFG_START_TWO, two);
		cfg_write(CFG_END, eof);
		cfg_valid <= 1'b0;
	endtask

	// Build one frame for the current delimiters and push it out.
	// hdr packs version, type, flags, sequence from the top byte down.
	task automatic send_frame(input frame_kind_e kind, input logic [LEN_W-1:0] len,
			input logic [31:0] hdr);
		logic [BYTE_W-1:0] body [$];
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] eof;
		int                n;
		if (kind == FK_NOISE) begin
			// line junk; mostly ignored while hunting
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom));
			return;
		end
		if (kind == FK_BAD_SOF) begin
			// first delimiter followed by anything but the second one
			send_byte(sb.sof_one);
			send_byte(sb.sof_two ^ 8'($urandom_range(1, 255)));
			frame_bytes += 2;
			return;
		end
		body = {hdr[31:24], hdr[23:16], hdr[15:8], hdr[7:0], len[7:0], len[15:8]};
		if (kind != FK_BAD_LEN)
			for (int i = 0; i < len; i++)
				body.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (body[i])
			crc = frame_scoreboard::crc_step(crc, body[i]);
		if (kind == FK_BAD_CRC)
			crc ^= 16'(1) << $urandom_range(15);
		eof = sb.eof_byte;
		if (kind == FK_BAD_END) begin
			eof = sb.eof_byte ^ 8'($urandom_range(1, 255));
			// wrong end byte wins whatever the CRC
			if ($urandom_range(1))
				crc = 16'($urandom);
		end
		send_byte(sb.sof_one);
		send_byte(sb.sof_two);
		foreach (body[i])
			send_byte(body[i]);
		frame_bytes += body.size() + 2;
		// oversize length aborts right after the length field
		if (kind != FK_BAD_LEN) begin
			send_byte(crc[7:0]);
			send_byte(crc[15:8]);
			send_byte(eof);
			frame_bytes += 3;
		end
	endtask

	function automatic frame_kind_e pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return FK_GOOD;
		else if (r < 65)
			return FK_BAD_CRC;
		else if (r < 75)
			return FK_BAD_END;
		else if (r < 83)
			return FK_BAD_LEN;
		else if (r < 90)
			return FK_BAD_SOF;
		return FK_NOISE;
	endfunction

	// mostly short payloads; empty, full and one-short-of-full now and then
	function automatic logic [LEN_W-1:0] pick_len(frame_kind_e kind);
		int r;
		if (kind == FK_BAD_LEN)
			return $urandom_range(1) ? LEN_W'(DEPTH + 1)
				: LEN_W'($urandom_range(DEPTH + 1, 65535));
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 16)
			return LEN_W'(DEPTH);
		else if (r < 19)
			return LEN_W'(DEPTH - 1);
		return LEN_W'($urandom_range(1, 8));
	endfunction

	task automatic random_frames(input int budget);
		frame_kind_e kind;
		frame_bytes = 0;
		while (frame_bytes < budget) begin
			kind = pick_kind();
			send_frame(kind, pick_len(kind), $urandom);
		end
	endtask

	// stop sending, let every predicted result arrive, then give the
	// header-byte CRC pipeline time to finish a byte that makes no result
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset delimiters: broken start pair, empty frame with
		// all-ones/all-zeros header bytes, maximum oversize length
		send_frame(FK_BAD_SOF, '0, '0);
		send_frame(FK_GOOD, 16'h0000, 32'hFF00_FF00);
		send_frame(FK_BAD_LEN, 16'hFFFF, 32'h00FF_00FF);
		drain();

		// all-zero / all-one delimiters, no idling on either side
		idle_en = 1'b0;
		load_config(8'h00, 8'hFF, 8'h00);
		random_frames(PHASE_BYTES);
		drain();
		idle_en = 1'b1;

		// inverted extremes; poke the unused index; long result hold-off
		// over a full payload so the input side backs up
		cfg_write(CFG_UNUSED, 8'($urandom));
		load_config(8'hFF, 8'h00, 8'hFF);
		hold_req = 1'b1;
		send_frame(FK_GOOD, LEN_W'(DEPTH), $urandom);
		random_frames(PHASE_BYTES);
		drain();

		// arbitrary delimiters, collisions between them allowed
		load_config(8'($urandom), 8'($urandom), 8'($urandom));
		random_frames(PHASE_BYTES);
		drain();

		// back to the reset values, written explicitly
		load_config(RST_START_ONE, RST_START_TWO, RST_END);
		random_frames(PHASE_BYTES);
		drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: frame_receive_crc_check.f
+incdir+hw/rtl
hw/rtl/frc_pkg.sv
hw/rtl/frc_crc_unit.sv
hw/rtl/frc_payload_ram.sv
hw/rtl/frame_receive_crc_check.sv
tb/tb.sv
